@@ rtl/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// Polar/rectangular converter package
// Shared constants, control codes, the stage control bundle and the
// arctangent table for the CORDIC pipeline.
// ----------------------------------------------------------------------------
package prc_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int ITERATIONS_DEFAULT  = 16;
   localparam int MAX_ITERATIONS      = 32;

   // Fraction bits added to coordinates inside the datapath, and guard bits
   // that absorb the CORDIC gain and the sign.
   localparam int EXTRA_FRAC = 16;
   localparam int DATA_GUARD = 3;

   // Angles inside the datapath are degrees * 2^24.
   localparam int ANGLE_SHIFT = 24;
   // Shift between degrees * 2^24 and the Q8.7 angle field.
   localparam int ANGLE_Q_SHIFT = 17;
   localparam int Z_WIDTH       = 33;
   // Rounded Q8.7 angle including the +/-180 base before wrapping.
   localparam int ANGLE_WIDTH   = 18;

   localparam logic [29:0] INV_GAIN  = 30'd652032874;
   localparam int          GAIN_FRAC = 30;

   localparam int     HALF_TURN_DEG = 180;
   localparam int     HALF_TURN     = 23040;
   localparam int     QUARTER_TURN  = 11520;
   localparam int     FULL_TURN     = 46080;
   localparam longint DEG_PER_RAD   = 64'sd961263669;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ORIGIN  = 2'd1;
   localparam logic [1:0] STATUS_NEG_RAD = 2'd2;
   localparam logic [1:0] STATUS_RANGE   = 2'd3;

   // Angle of a point that lies exactly on an axis.
   typedef enum logic [1:0] {
      AXIS_ZERO    = 2'd0,
      AXIS_POS_QTR = 2'd1,
      AXIS_NEG_QTR = 2'd2,
      AXIS_HALF    = 2'd3
   } prc_axis_type;

   // Base angle added after vectoring a point from the left half plane.
   typedef enum logic [1:0] {
      BASE_ZERO = 2'd0,
      BASE_POS  = 2'd1,
      BASE_NEG  = 2'd2
   } prc_base_type;

   typedef struct packed {
      logic         kind;
      logic [1:0]   status;
      logic         on_axis;
      prc_axis_type axis_angle;
      prc_base_type base;
      logic         flip;
   } prc_ctl_type;

   localparam longint ATAN_HEAD [0:10] = '{
      64'sd754974720, 64'sd445687602, 64'sd235489088, 64'sd119537938,
      64'sd60000934,  64'sd30029717,  64'sd15018523,  64'sd7509720,
      64'sd3754917,   64'sd1877466,   64'sd938734
   };

   // atan(2^-idx) in degrees * 2^24. Past the listed entries the small
   // angle form (180/pi) / 2^idx, rounded half up, is exact enough.
   function automatic logic [29:0] atan_step(input int idx);
      longint value;
      begin
         if (idx < 11) begin
            value = ATAN_HEAD[idx];
         end else begin
            value = (DEG_PER_RAD + (64'sd1 <<< (idx - 1))) >>> idx;
         end
         return value[29:0];
      end
   endfunction

endpackage

@@ rtl/prc_if.sv @@
// ----------------------------------------------------------------------------
// Polar/rectangular converter channels
// Valid/ready channels for the request and the response beats.
// ----------------------------------------------------------------------------
interface prc_req_if #(
   parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic signed [COORD_WIDTH-1:0] first_operand;
   logic signed [COORD_WIDTH-1:0] second_operand;

   modport source (output valid, kind, first_operand, second_operand, input ready);
   modport sink (input valid, kind, first_operand, second_operand, output ready);
endinterface

interface prc_rsp_if #(
   parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH:0]   first_result;
   logic signed [COORD_WIDTH-1:0] second_result;
   logic [1:0]                    status;

   modport source (output valid, first_result, second_result, status, input ready);
   modport sink (input valid, first_result, second_result, status, output ready);
endinterface

@@ rtl/polar_rectangular_converter_core.sv @@
// The pipeline has ITERATIONS + 5 register stages, with ITERATIONS capped
// at MAX_ITERATIONS for the micro-rotation chain.
// Throughput: one beat per cycle unless the response side stalls; every
// stage holds one beat and the micro-rotation chain, one per iteration, sets the depth.
// Reset clears the valid bit of every stage; payload registers are not reset.
// ----------------------------------------------------------------------------
// Polar/rectangular converter core
// Pipelined CORDIC converting cartesian to polar and polar to cartesian.
// ----------------------------------------------------------------------------
module polar_rectangular_converter_core #(
   parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEFAULT,
   parameter int ITERATIONS  = prc_pkg::ITERATIONS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   prc_req_if.sink   req_ch,
   prc_rsp_if.source rsp_ch
);

   localparam int STAGES = (ITERATIONS > prc_pkg::MAX_ITERATIONS) ?
                           prc_pkg::MAX_ITERATIONS : ITERATIONS;
   localparam int DW = COORD_WIDTH + prc_pkg::EXTRA_FRAC + prc_pkg::DATA_GUARD;
   localparam int ZW = prc_pkg::Z_WIDTH;

   logic                      st_valid [0:STAGES];
   logic                      st_ready [0:STAGES];
   prc_pkg::prc_ctl_type      st_ctl   [0:STAGES];
   logic [COORD_WIDTH:0]      st_mag   [0:STAGES];
   logic signed [DW-1:0]      st_cx    [0:STAGES];
   logic signed [DW-1:0]      st_cy    [0:STAGES];
   logic signed [ZW-1:0]      st_z     [0:STAGES];

   prc_prep #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_prep (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (req_ch.valid),
      .up_ready       (req_ch.ready),
      .kind           (req_ch.kind),
      .first_operand  (req_ch.first_operand),
      .second_operand (req_ch.second_operand),
      .dn_valid       (st_valid[0]),
      .dn_ready       (st_ready[0]),
      .dn_ctl         (st_ctl[0]),
      .dn_axis_mag    (st_mag[0]),
      .dn_cx          (st_cx[0]),
      .dn_cy          (st_cy[0]),
      .dn_z           (st_z[0])
   );

   for (genvar k = 0; k < STAGES; k++) begin : g_rot
      prc_rotator #(
         .COORD_WIDTH (COORD_WIDTH),
         .STAGE       (k)
      ) u_rot (
         .clock       (clock),
         .reset       (reset),
         .up_valid    (st_valid[k]),
         .up_ready    (st_ready[k]),
         .up_ctl      (st_ctl[k]),
         .up_axis_mag (st_mag[k]),
         .up_cx       (st_cx[k]),
         .up_cy       (st_cy[k]),
         .up_z        (st_z[k]),
         .dn_valid    (st_valid[k+1]),
         .dn_ready    (st_ready[k+1]),
         .dn_ctl      (st_ctl[k+1]),
         .dn_axis_mag (st_mag[k+1]),
         .dn_cx       (st_cx[k+1]),
         .dn_cy       (st_cy[k+1]),
         .dn_z        (st_z[k+1])
      );
   end

   prc_post #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_post (
      .clock            (clock),
      .reset            (reset),
      .up_valid         (st_valid[STAGES]),
      .up_ready         (st_ready[STAGES]),
      .up_ctl           (st_ctl[STAGES]),
      .up_axis_mag      (st_mag[STAGES]),
      .up_cx            (st_cx[STAGES]),
      .up_cy            (st_cy[STAGES]),
      .up_z             (st_z[STAGES]),
      .dn_valid         (rsp_ch.valid),
      .dn_ready         (rsp_ch.ready),
      .dn_first_result  (rsp_ch.first_result),
      .dn_second_result (rsp_ch.second_result),
      .dn_status        (rsp_ch.status)
   );

endmodule

@@ rtl/prc_prep.sv @@
// ----------------------------------------------------------------------------
// Polar/rectangular converter front end
// Two register stages: classify the beat, fold the angle and scale the
// radius, then load the CORDIC start vector and angle accumulator.
// ----------------------------------------------------------------------------
module prc_prep #(
   parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic                          kind,
   input  logic signed [COORD_WIDTH-1:0] first_operand,
   input  logic signed [COORD_WIDTH-1:0] second_operand,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output prc_pkg::prc_ctl_type          dn_ctl,
   output logic [COORD_WIDTH:0]          dn_axis_mag,
   output logic signed [COORD_WIDTH+prc_pkg::EXTRA_FRAC+prc_pkg::DATA_GUARD-1:0] dn_cx,
   output logic signed [COORD_WIDTH+prc_pkg::EXTRA_FRAC+prc_pkg::DATA_GUARD-1:0] dn_cy,
   output logic signed [prc_pkg::Z_WIDTH-1:0] dn_z
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + prc_pkg::EXTRA_FRAC + prc_pkg::DATA_GUARD;
   localparam int ZW  = prc_pkg::Z_WIDTH;
   localparam int PW  = CW + prc_pkg::GAIN_FRAC + 1;
   localparam int RS  = prc_pkg::GAIN_FRAC - prc_pkg::EXTRA_FRAC;
   localparam int AQW = ((CW > 16) ? CW : 16) + 1;
   localparam int AFW = ZW - prc_pkg::ANGLE_Q_SHIFT;

   localparam logic signed [AQW-1:0] QTR_Q  = AQW'(prc_pkg::QUARTER_TURN);
   localparam logic signed [AQW-1:0] HALF_Q = AQW'(prc_pkg::HALF_TURN);
   localparam logic signed [PW-1:0]  PROD_HALF = PW'(1) <<< (RS - 1);

   // Stage 0 registers.
   logic                 v0_ff, v0_in;
   prc_pkg::prc_ctl_type ctl0_ff, ctl0_in;
   logic [CW:0]          mag0_ff, mag0_in;
   logic signed [CW:0]   x0_ff, x0_in;
   logic signed [CW:0]   y0_ff, y0_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [ZW-1:0] z0_ff, z0_in;

   // Stage 1 registers.
   logic                 v1_ff, v1_in;
   prc_pkg::prc_ctl_type ctl1_ff;
   logic [CW:0]          mag1_ff;
   logic signed [DW-1:0] cx1_ff, cx1_in;
   logic signed [DW-1:0] cy1_ff, cy1_in;
   logic signed [ZW-1:0] z1_ff, z1_in;

   logic                  ready0, ready1, load0, load1;
   logic                  p_zero, q_zero, p_neg, q_neg, q_pos;
   logic signed [CW:0]    p_ext, q_ext, p_abs, q_abs;
   logic signed [AQW-1:0] a_ext, a_fold;
   logic                  a_above, a_below;
   logic signed [PW-1:0]  prod_rnd;

   assign ready1   = !v1_ff || dn_ready;
   assign ready0   = !v0_ff || ready1;
   assign up_ready = ready0;
   assign load0    = up_valid && ready0;
   assign load1    = v0_ff && ready1;

   always_comb begin
      p_zero = (first_operand == '0);
      q_zero = (second_operand == '0);
      p_neg  = first_operand[CW-1];
      q_neg  = second_operand[CW-1];
      q_pos  = !q_neg && !q_zero;
      p_ext  = {first_operand[CW-1], first_operand};
      q_ext  = {second_operand[CW-1], second_operand};
      p_abs  = p_neg ? -p_ext : p_ext;
      q_abs  = q_neg ? -q_ext : q_ext;

      a_ext   = {{(AQW-CW){second_operand[CW-1]}}, second_operand};
      a_above = (a_ext > QTR_Q);
      a_below = (a_ext < -QTR_Q);
      if (a_above) begin
         a_fold = a_ext - HALF_Q;
      end else if (a_below) begin
         a_fold = a_ext + HALF_Q;
      end else begin
         a_fold = a_ext;
      end

      ctl0_in.kind    = kind;
      ctl0_in.on_axis = p_zero || q_zero;
      ctl0_in.flip    = a_above || a_below;
      if (kind) begin
         if (p_neg) begin
            ctl0_in.status = prc_pkg::STATUS_NEG_RAD;
         end else if ((a_ext < -HALF_Q) || (a_ext > HALF_Q)) begin
            ctl0_in.status = prc_pkg::STATUS_RANGE;
         end else begin
            ctl0_in.status = prc_pkg::STATUS_OK;
         end
      end else begin
         ctl0_in.status = (p_zero && q_zero) ? prc_pkg::STATUS_ORIGIN : prc_pkg::STATUS_OK;
      end
      if (q_zero) begin
         ctl0_in.axis_angle = p_neg ? prc_pkg::AXIS_HALF : prc_pkg::AXIS_ZERO;
      end else begin
         ctl0_in.axis_angle = q_neg ? prc_pkg::AXIS_NEG_QTR : prc_pkg::AXIS_POS_QTR;
      end
      // A point in the left half plane is turned by 180 degrees first.
      if (!kind && p_neg) begin
         ctl0_in.base = q_pos ? prc_pkg::BASE_POS : prc_pkg::BASE_NEG;
      end else begin
         ctl0_in.base = prc_pkg::BASE_ZERO;
      end

      mag0_in = q_zero ? p_abs : q_abs;
      x0_in   = p_neg ? -p_ext : p_ext;
      y0_in   = p_neg ? -q_ext : q_ext;
      prod_in = PW'(first_operand) * $signed({1'b0, prc_pkg::INV_GAIN});
      z0_in   = {a_fold[AFW-1:0], {prc_pkg::ANGLE_Q_SHIFT{1'b0}}};
      v0_in   = ready0 ? up_valid : v0_ff;
   end

   always_comb begin
      prod_rnd = prod_ff + PROD_HALF;
      if (ctl0_ff.kind) begin
         cx1_in = DW'($signed(prod_rnd[PW-1:RS]));
         cy1_in = '0;
         z1_in  = z0_ff;
      end else begin
         cx1_in = DW'($signed({x0_ff, {prc_pkg::EXTRA_FRAC{1'b0}}}));
         cy1_in = DW'($signed({y0_ff, {prc_pkg::EXTRA_FRAC{1'b0}}}));
         z1_in  = '0;
      end
      v1_in = ready1 ? v0_ff : v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load0) begin
         ctl0_ff <= ctl0_in;
         mag0_ff <= mag0_in;
         x0_ff   <= x0_in;
         y0_ff   <= y0_in;
         prod_ff <= prod_in;
         z0_ff   <= z0_in;
      end
      if (load1) begin
         ctl1_ff <= ctl0_ff;
         mag1_ff <= mag0_ff;
         cx1_ff  <= cx1_in;
         cy1_ff  <= cy1_in;
         z1_ff   <= z1_in;
      end
   end

   assign dn_valid    = v1_ff;
   assign dn_ctl      = ctl1_ff;
   assign dn_axis_mag = mag1_ff;
   assign dn_cx       = cx1_ff;
   assign dn_cy       = cy1_ff;
   assign dn_z        = z1_ff;

endmodule

@@ rtl/prc_rotator.sv @@
// ----------------------------------------------------------------------------
// Polar/rectangular converter micro-rotation stage
// One registered CORDIC step: vectoring for cartesian input, rotation for
// polar input.
// ----------------------------------------------------------------------------
module prc_rotator #(
   parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEFAULT,
   parameter int STAGE       = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  prc_pkg::prc_ctl_type up_ctl,
   input  logic [COORD_WIDTH:0] up_axis_mag,
   input  logic signed [COORD_WIDTH+prc_pkg::EXTRA_FRAC+prc_pkg::DATA_GUARD-1:0] up_cx,
   input  logic signed [COORD_WIDTH+prc_pkg::EXTRA_FRAC+prc_pkg::DATA_GUARD-1:0] up_cy,
   input  logic signed [prc_pkg::Z_WIDTH-1:0] up_z,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output prc_pkg::prc_ctl_type dn_ctl,
   output logic [COORD_WIDTH:0] dn_axis_mag,
   output logic signed [COORD_WIDTH+prc_pkg::EXTRA_FRAC+prc_pkg::DATA_GUARD-1:0] dn_cx,
   output logic signed [COORD_WIDTH+prc_pkg::EXTRA_FRAC+prc_pkg::DATA_GUARD-1:0] dn_cy,
   output logic signed [prc_pkg::Z_WIDTH-1:0] dn_z
);

   localparam int DW = COORD_WIDTH + prc_pkg::EXTRA_FRAC + prc_pkg::DATA_GUARD;
   localparam int ZW = prc_pkg::Z_WIDTH;
   localparam logic signed [ZW-1:0] ATAN = ZW'(prc_pkg::atan_step(STAGE));

   logic                 valid_ff, valid_in;
   prc_pkg::prc_ctl_type ctl_ff;
   logic [COORD_WIDTH:0] mag_ff;
   logic signed [DW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [DW-1:0] dx, dy;
   logic                 turn_down, load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      dx = up_cy >>> STAGE;
      dy = up_cx >>> STAGE;
      // Vectoring steers y toward zero; rotation steers the angle toward zero.
      turn_down = up_ctl.kind ? up_z[ZW-1] : !up_cy[DW-1];
      if (turn_down) begin
         cx_in = up_cx + dx;
         cy_in = up_cy - dy;
         z_in  = up_z + ATAN;
      end else begin
         cx_in = up_cx - dx;
         cy_in = up_cy + dy;
         z_in  = up_z - ATAN;
      end
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff <= up_ctl;
         mag_ff <= up_axis_mag;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         z_ff   <= z_in;
      end
   end

   assign dn_valid    = valid_ff;
   assign dn_ctl      = ctl_ff;
   assign dn_axis_mag = mag_ff;
   assign dn_cx       = cx_ff;
   assign dn_cy       = cy_ff;
   assign dn_z        = z_ff;

endmodule

@@ rtl/prc_post.sv @@
// ----------------------------------------------------------------------------
// Polar/rectangular converter back end
// Three register stages: gain partial products, angle sum and rounded
// coordinates, gain sum with rounding, angle wrap and coordinate unfold, then
// result selection, saturation and the response register.
// ----------------------------------------------------------------------------
module prc_post #(
   parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  prc_pkg::prc_ctl_type up_ctl,
   input  logic [COORD_WIDTH:0] up_axis_mag,
   input  logic signed [COORD_WIDTH+prc_pkg::EXTRA_FRAC+prc_pkg::DATA_GUARD-1:0] up_cx,
   input  logic signed [COORD_WIDTH+prc_pkg::EXTRA_FRAC+prc_pkg::DATA_GUARD-1:0] up_cy,
   input  logic signed [prc_pkg::Z_WIDTH-1:0] up_z,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output logic signed [COORD_WIDTH:0]   dn_first_result,
   output logic signed [COORD_WIDTH-1:0] dn_second_result,
   output logic [1:0]                    dn_status
);

   localparam int CW    = COORD_WIDTH;
   localparam int EF    = prc_pkg::EXTRA_FRAC;
   localparam int DW    = CW + EF + prc_pkg::DATA_GUARD;
   localparam int ZW    = prc_pkg::Z_WIDTH;
   localparam int SPLIT = 25;
   localparam int HW    = DW - 1 - SPLIT;
   localparam int LPW   = SPLIT + prc_pkg::GAIN_FRAC;
   localparam int HPW   = HW + prc_pkg::GAIN_FRAC;
   localparam int SD    = HPW + SPLIT;
   localparam int MSH   = prc_pkg::GAIN_FRAC + EF;
   localparam int MW    = SD - MSH;
   localparam int RW    = DW - EF;
   localparam int ASW   = ZW + 2;
   localparam int AW    = prc_pkg::ANGLE_WIDTH;
   localparam int SW    = ((CW + 4) > AW) ? (CW + 4) : AW;

   localparam logic signed [ASW-1:0] BASE_Q =
      ASW'(longint'(prc_pkg::HALF_TURN_DEG) <<< prc_pkg::ANGLE_SHIFT);
   localparam logic signed [ASW-1:0] ANG_HALF_LSB = ASW'(1) <<< (prc_pkg::ANGLE_Q_SHIFT - 1);
   localparam logic signed [DW-1:0]  CO_HALF_LSB  = DW'(1) <<< (EF - 1);
   localparam logic [SD-1:0]         MAG_HALF_LSB = SD'(1) << (MSH - 1);
   localparam logic signed [AW-1:0]  HALF_A = AW'(prc_pkg::HALF_TURN);
   localparam logic signed [AW-1:0]  FULL_A = AW'(prc_pkg::FULL_TURN);
   localparam logic signed [SW-1:0]  HALF_S = SW'(prc_pkg::HALF_TURN);
   localparam logic signed [SW-1:0]  QTR_S  = SW'(prc_pkg::QUARTER_TURN);
   localparam logic signed [SW-1:0]  HI1 = {{(SW-CW){1'b0}}, {CW{1'b1}}};
   localparam logic signed [SW-1:0]  LO1 = {{(SW-CW){1'b1}}, {CW{1'b0}}};
   localparam logic signed [SW-1:0]  HI0 = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0]  LO0 = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   // Stage 1: partial products of the gain, angle sum, rounded coordinates.
   logic                  v1_ff, v1_in;
   prc_pkg::prc_ctl_type  ctl1_ff;
   logic [CW:0]           amag1_ff;
   logic [LPW-1:0]        plo_ff, plo_in;
   logic [HPW-1:0]        phi_ff, phi_in;
   logic signed [ASW-1:0] asum_ff, asum_in;
   logic signed [RW-1:0]  rx_ff, rx_in, ry_ff, ry_in;

   // Stage 2: magnitude, wrapped angle, unfolded coordinates.
   logic                  v2_ff, v2_in;
   prc_pkg::prc_ctl_type  ctl2_ff;
   logic [CW:0]           amag2_ff;
   logic [MW-1:0]         mag_ff, mag_in;
   logic signed [AW-1:0]  ang_ff, ang_in;
   logic signed [RW:0]    fx_ff, fx_in, fy_ff, fy_in;

   // Stage 3: response register.
   logic                  v3_ff, v3_in;
   logic signed [CW:0]    res1_ff, res1_in;
   logic signed [CW-1:0]  res2_ff, res2_in;
   logic [1:0]            stat_ff;

   logic                  ready1, ready2, ready3, load1, load2, load3;
   logic [DW-2:0]         cx_pos;
   logic [SPLIT-1:0]      cx_lo;
   logic [HW-1:0]         cx_hi;
   logic signed [ASW-1:0] base_val, ang_rnd;
   logic signed [DW-1:0]  cx_rnd, cy_rnd;
   logic [SD-1:0]         mag_sum;
   logic signed [AW-1:0]  ang_raw;
   logic signed [RW:0]    rx_ext, ry_ext;
   logic signed [SW-1:0]  sel1, sel2, axis_ang;

   assign ready3   = !v3_ff || dn_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign up_ready = ready1;
   assign load1    = up_valid && ready1;
   assign load2    = v1_ff && ready2;
   assign load3    = v2_ff && ready3;

   always_comb begin
      cx_pos = up_cx[DW-1] ? '0 : up_cx[DW-2:0];
      cx_lo  = cx_pos[SPLIT-1:0];
      cx_hi  = cx_pos[DW-2:SPLIT];
      plo_in = LPW'(cx_lo) * LPW'(prc_pkg::INV_GAIN);
      phi_in = HPW'(cx_hi) * HPW'(prc_pkg::INV_GAIN);
      case (up_ctl.base)
         prc_pkg::BASE_POS: base_val = BASE_Q;
         prc_pkg::BASE_NEG: base_val = -BASE_Q;
         default:           base_val = '0;
      endcase
      asum_in = ASW'(up_z) + base_val;
      cx_rnd  = up_cx + CO_HALF_LSB;
      cy_rnd  = up_cy + CO_HALF_LSB;
      rx_in   = cx_rnd[DW-1:EF];
      ry_in   = cy_rnd[DW-1:EF];
      v1_in   = ready1 ? up_valid : v1_ff;
   end

   always_comb begin
      // The split products recombine to cx * gain, rounded to an unsigned integer (UQ18.0 at CW = 16).
      mag_sum = {phi_ff, {SPLIT{1'b0}}} + SD'(plo_ff) + MAG_HALF_LSB;
      mag_in  = mag_sum[SD-1:MSH];
      ang_rnd = asum_ff + ANG_HALF_LSB;
      ang_raw = ang_rnd[ASW-1:prc_pkg::ANGLE_Q_SHIFT];
      if (ang_raw <= -HALF_A) begin
         ang_in = ang_raw + FULL_A;
      end else if (ang_raw > HALF_A) begin
         ang_in = ang_raw - FULL_A;
      end else begin
         ang_in = ang_raw;
      end
      rx_ext = (RW + 1)'(rx_ff);
      ry_ext = (RW + 1)'(ry_ff);
      fx_in  = ctl1_ff.flip ? -rx_ext : rx_ext;
      fy_in  = ctl1_ff.flip ? -ry_ext : ry_ext;
      v2_in  = ready2 ? v1_ff : v2_ff;
   end

   always_comb begin
      case (ctl2_ff.axis_angle)
         prc_pkg::AXIS_POS_QTR: axis_ang = QTR_S;
         prc_pkg::AXIS_NEG_QTR: axis_ang = -QTR_S;
         prc_pkg::AXIS_HALF:    axis_ang = HALF_S;
         default:               axis_ang = '0;
      endcase
      if (ctl2_ff.status != prc_pkg::STATUS_OK) begin
         sel1 = '0;
         sel2 = '0;
      end else if (ctl2_ff.kind) begin
         sel1 = SW'(fx_ff);
         sel2 = SW'(fy_ff);
      end else if (ctl2_ff.on_axis) begin
         sel1 = SW'(amag2_ff);
         sel2 = axis_ang;
      end else begin
         sel1 = SW'(mag_ff);
         sel2 = SW'(ang_ff);
      end
      if (sel1 > HI1) begin
         res1_in = HI1[CW:0];
      end else if (sel1 < LO1) begin
         res1_in = LO1[CW:0];
      end else begin
         res1_in = sel1[CW:0];
      end
      if (sel2 > HI0) begin
         res2_in = HI0[CW-1:0];
      end else if (sel2 < LO0) begin
         res2_in = LO0[CW-1:0];
      end else begin
         res2_in = sel2[CW-1:0];
      end
      v3_in = ready3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         ctl1_ff  <= up_ctl;
         amag1_ff <= up_axis_mag;
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         asum_ff  <= asum_in;
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
      end
      if (load2) begin
         ctl2_ff  <= ctl1_ff;
         amag2_ff <= amag1_ff;
         mag_ff   <= mag_in;
         ang_ff   <= ang_in;
         fx_ff    <= fx_in;
         fy_ff    <= fy_in;
      end
      if (load3) begin
         res1_ff <= res1_in;
         res2_ff <= res2_in;
         stat_ff <= ctl2_ff.status;
      end
   end

   assign dn_valid         = v3_ff;
   assign dn_first_result  = res1_ff;
   assign dn_second_result = res2_ff;
   assign dn_status        = stat_ff;

endmodule
